@@ rtl/core/ttle_pkg.sv @@
`default_nettype none
package ttle_pkg;

   // register indexes
   localparam logic [1:0] CSR_NUM_DIMS    = 2'd0;
   localparam logic [1:0] CSR_RANKS       = 2'd1;
   localparam logic [1:0] CSR_BASIS       = 2'd2;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_BASIS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_FUNC,
      ST_TERM,
      ST_COPY,
      ST_RESULT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear;
      logic load_item;
      logic mac;
      logic func_end;
      logic term_add;
      logic copy;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic func_done;
      logic row_wrap;
      logic col_wrap;
      logic is_last;
      logic is_basis;
      logic out_full;
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/core/tensor_train_linear_eval_core.sv @@
// channel | direction | handshake          | payload
// req     | in        | req_valid/req_stall | type, param_addr, value, last
// rsp     | out       | rsp_valid/rsp_stall | eval_value, saturated, length_error
// csr     | in        | csr_write           | csr_index, csr_data
// a write passes through idle and mac; a basis value does too, then func
// and term when it closes a function (round and rank product, then add) and
// copy when it closes a core. an item with last set then loads the result
// in the result state, which waits while rsp_stall holds the old result.
// a result is registered and the next item is taken while it waits.
// reset is synchronous; the parameter store is not cleared.
`default_nettype none
module tensor_train_linear_eval_core
   import ttle_pkg::*;
#(
   parameter int MAX_DIMS    = 8,
   parameter int MAX_RANK    = 8,
   parameter int PARAM_DEPTH = 4096,
   parameter int MAX_BASIS   = 63
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_type,
   input  wire logic [11:0] req_param_addr,
   input  wire logic signed [31:0] req_value,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_eval_value,
   output logic             rsp_saturated,
   output logic             rsp_length_error,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   ttle_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .sts      (sts),
      .cmd      (cmd)
   );

   ttle_dp #(
      .MAX_DIMS(MAX_DIMS), .MAX_RANK(MAX_RANK),
      .PARAM_DEPTH(PARAM_DEPTH), .MAX_BASIS(MAX_BASIS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_type(req_type), .req_param_addr(req_param_addr),
      .req_value(req_value), .req_last(req_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_eval_value(rsp_eval_value), .rsp_saturated(rsp_saturated),
      .rsp_length_error(rsp_length_error)
   );
endmodule
`default_nettype wire

@@ rtl/core/ttle_ram.sv @@
`default_nettype none
module ttle_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

@@ rtl/core/ttle_ctrl.sv @@
`default_nettype none
module ttle_ctrl
   import ttle_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);
   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (!sts.is_basis) begin
               state_in = ST_IDLE;
            end else begin
               cmd.mac = 1'b1;
               if (sts.func_done) begin
                  state_in = ST_FUNC;
               end else if (sts.is_last) begin
                  state_in = ST_RESULT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FUNC: begin
            cmd.func_end = 1'b1;
            state_in = ST_TERM;
         end
         ST_TERM: begin
            cmd.term_add = 1'b1;
            if (sts.row_wrap && sts.col_wrap) begin
               state_in = ST_COPY;
            end else if (sts.is_last) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_COPY: begin
            cmd.copy = 1'b1;
            state_in = sts.is_last ? ST_RESULT : ST_IDLE;
         end
         ST_RESULT: begin
            if (!sts.out_full) begin
               cmd.out_load = 1'b1;
               cmd.clear = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

@@ rtl/core/ttle_dp.sv @@
`default_nettype none
module ttle_dp
   import ttle_pkg::*;
#(
   parameter int MAX_DIMS    = 8,
   parameter int MAX_RANK    = 8,
   parameter int PARAM_DEPTH = 4096,
   parameter int MAX_BASIS   = 63
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   input  wire logic        req_type,
   input  wire logic [11:0] req_param_addr,
   input  wire logic signed [31:0] req_value,
   input  wire logic        req_last,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [47:0] csr_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic signed [31:0] rsp_eval_value,
   output logic             rsp_saturated,
   output logic             rsp_length_error
);
   localparam int AW = $clog2(PARAM_DEPTH);
   localparam int RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int CW = $clog2(MAX_DIMS + 1);
   localparam int BW = $clog2(MAX_BASIS + 1);
   localparam logic signed [63:0] MAX64 = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] MIN64 = {1'b1, {63{1'b0}}};
   localparam logic signed [63:0] MAX32 = 64'sd2147483647;
   localparam logic signed [63:0] MIN32 = -64'sd2147483648;
   localparam logic signed [63:0] MAX48 = 64'sh00007FFFFFFFFFFF;
   localparam logic signed [63:0] MIN48 = -64'sh0000800000000000;

   // configuration registers
   logic [3:0]  dims_ff;
   logic [27:0] ranks_ff;
   logic [47:0] basis_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff  <= 4'd1;
         ranks_ff <= 28'd17895697;
         basis_ff <= 48'd4467856773185;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NUM_DIMS: dims_ff  <= csr_data[3:0];
            CSR_RANKS:    ranks_ff <= csr_data[27:0];
            CSR_BASIS:    basis_ff <= csr_data;
            default: ;
         endcase
      end
   end
   logic csr_clear;
   assign csr_clear = csr_write && (csr_index == CSR_NUM_DIMS || csr_index == CSR_RANKS
                                    || csr_index == CSR_BASIS);

   // captured item
   logic        type_ff, last_ff;
   logic [11:0] addr_ff;
   logic signed [31:0] value_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         type_ff  <= req_type;
         last_ff  <= req_last;
         addr_ff  <= req_param_addr;
         value_ff <= req_value;
      end
   end

   // sample state
   logic [CW-1:0] core_ff;
   logic [RW:0]   row_ff, col_ff;
   logic [BW-1:0] basis_cnt_ff;
   logic [AW-1:0] pos_ff;
   logic signed [63:0] acc_ff;
   logic signed [31:0] dot_ff;
   logic signed [31:0] prev_ff [MAX_RANK];
   logic signed [47:0] next_ff [MAX_RANK];
   logic sat_ff, over_ff;
   logic signed [63:0] prod_ff;

   // effective shape
   logic [CW-1:0] dims_eff;
   always_comb begin
      if (dims_ff == 4'd0) dims_eff = CW'(1);
      else if (32'(dims_ff) > MAX_DIMS) dims_eff = CW'(MAX_DIMS);
      else dims_eff = CW'(dims_ff);
   end

   function automatic logic [RW:0] rank_of(input logic [CW:0] k, input logic [CW-1:0] d,
                                          input logic [27:0] rp);
      logic [3:0] r;
      r = 4'd1;
      if (k != '0 && 32'(k) < 32'(d) && 32'(k) <= 7) begin
         r = rp[4*(k-1) +: 4];
         if (r == 4'd0) r = 4'd1;
         if (32'(r) > MAX_RANK) r = 4'(MAX_RANK);
      end
      return (RW+1)'(r);
   endfunction

   logic [RW:0] rank_in_c, rank_out_c;
   logic [BW-1:0] basis_c;
   logic [5:0] b6;
   assign rank_in_c  = rank_of({1'b0, core_ff}, dims_eff, ranks_ff);
   assign rank_out_c = rank_of({1'b0, core_ff} + 1'b1, dims_eff, ranks_ff);
   always_comb begin
      b6 = (32'(core_ff) <= 7) ? basis_ff[6*core_ff[2:0] +: 6] : 6'd1;
      if (b6 == 6'd0) b6 = 6'd1;
      if (32'(b6) > MAX_BASIS) b6 = 6'(MAX_BASIS);
      basis_c = BW'(b6);
   end

   // parameter store
   logic [31:0] param_rd;
   logic st_wr;
   assign st_wr = cmd.load_item && req_type == REQ_WRITE
                  && 32'(req_param_addr) < PARAM_DEPTH;
   ttle_ram #(.WIDTH(32), .DEPTH(PARAM_DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (st_wr),
      .wr_addr(AW'(req_param_addr)),
      .wr_data(req_value),
      .rd_addr(pos_ff),
      .rd_data(param_rd)
   );

   logic active;
   assign active = core_ff < dims_eff;

   // multiply and saturating accumulate
   logic signed [63:0] prod_c, sum_c;
   logic sum_ovf;
   assign prod_c  = 64'(value_ff) * 64'($signed(param_rd));
   assign sum_c   = acc_ff + prod_c;
   assign sum_ovf = (acc_ff[63] == prod_c[63]) && (sum_c[63] != acc_ff[63]);

   // floor shift by 16 plus bit 15
   function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
      return (v >>> 16) + $signed(64'(v[15]));
   endfunction

   logic signed [63:0] dd_r, term_r, nsum;
   assign dd_r   = rnd16(acc_ff);
   assign term_r = rnd16(prod_ff);
   assign nsum   = (row_ff == '0 ? 64'sd0 : 64'(next_ff[col_ff[RW-1:0]])) + term_r;

   // dot product clipped to 32 bits
   logic signed [31:0] dd_c;
   logic dd_clip;
   always_comb begin
      dd_clip = 1'b1;
      if (dd_r > MAX32) begin
         dd_c = 32'sh7FFFFFFF;
      end else if (dd_r < MIN32) begin
         dd_c = 32'sh80000000;
      end else begin
         dd_c = dd_r[31:0];
         dd_clip = 1'b0;
      end
   end

   // sample state updates
   always_ff @(posedge clock) begin
      if (reset || cmd.clear || csr_clear) begin
         core_ff <= '0; row_ff <= '0; col_ff <= '0; basis_cnt_ff <= '0;
         pos_ff <= '0; acc_ff <= '0; sat_ff <= 1'b0; over_ff <= 1'b0;
         for (int i = 0; i < MAX_RANK; i++) begin
            prev_ff[i] <= '0;
            next_ff[i] <= '0;
         end
      end else begin
         if (cmd.mac) begin
            if (!active) begin
               over_ff <= 1'b1;
            end else begin
               if (sum_ovf) begin
                  sat_ff <= 1'b1;
                  acc_ff <= prod_c[63] ? MIN64 : MAX64;
               end else begin
                  acc_ff <= sum_c;
               end
               pos_ff <= pos_ff + 1'b1;
               basis_cnt_ff <= basis_cnt_ff + 1'b1;
            end
         end
         if (cmd.func_end) begin
            // round dot product and form the rank term product
            acc_ff <= '0;
            basis_cnt_ff <= '0;
            dot_ff <= dd_c;
            prod_ff <= 64'(prev_ff[row_ff[RW-1:0]]) * 64'(dd_c);
            if (dd_clip) begin
               sat_ff <= 1'b1;
            end
         end
         if (cmd.term_add) begin
            if (core_ff == '0) begin
               next_ff[col_ff[RW-1:0]] <= 48'(dot_ff);
            end else if (nsum > MAX48) begin
               sat_ff <= 1'b1; next_ff[col_ff[RW-1:0]] <= MAX48[47:0];
            end else if (nsum < MIN48) begin
               sat_ff <= 1'b1; next_ff[col_ff[RW-1:0]] <= MIN48[47:0];
            end else begin
               next_ff[col_ff[RW-1:0]] <= nsum[47:0];
            end
            if (row_ff + 1'b1 >= rank_in_c) begin
               row_ff <= '0;
               col_ff <= (col_ff + 1'b1 >= rank_out_c) ? '0 : col_ff + 1'b1;
            end else begin
               row_ff <= row_ff + 1'b1;
            end
         end
         if (cmd.copy) begin
            // close the core: saturate next into prev
            for (int i = 0; i < MAX_RANK; i++) begin
               if (64'(next_ff[i]) > MAX32) begin
                  prev_ff[i] <= 32'sh7FFFFFFF; sat_ff <= 1'b1;
               end else if (64'(next_ff[i]) < MIN32) begin
                  prev_ff[i] <= 32'sh80000000; sat_ff <= 1'b1;
               end else begin
                  prev_ff[i] <= next_ff[i][31:0];
               end
               next_ff[i] <= '0;
            end
            core_ff <= core_ff + 1'b1;
         end
      end
   end

   // status
   assign sts.func_done = active && (basis_cnt_ff + 1'b1 >= basis_c);
   assign sts.row_wrap  = row_ff + 1'b1 >= rank_in_c;
   assign sts.col_wrap  = col_ff + 1'b1 >= rank_out_c;
   assign sts.is_last   = last_ff;
   assign sts.is_basis  = type_ff == REQ_BASIS;
   assign sts.out_full  = rsp_valid && rsp_stall;

   // output register
   logic len_err;
   assign len_err = active || over_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_eval_value   <= len_err ? 32'sd0 : prev_ff[0];
         rsp_saturated    <= sat_ff;
         rsp_length_error <= len_err;
      end
   end
endmodule
`default_nettype wire

@@ rtl/core/ttle_checker.sv @@
`default_nettype none
module ttle_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_eval_value,
   input wire logic        rsp_length_error
);
   // held result stays
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_eval_value))
      else $error("result changed under stall");
   // length error forces zero value
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_length_error |-> rsp_eval_value == 32'd0)
      else $error("nonzero value with length error");
   // accepted item is followed by a busy cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("item taken twice in a row");
   // no result appears right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result after reset");
endmodule

bind tensor_train_linear_eval_core ttle_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_eval_value(rsp_eval_value), .rsp_length_error(rsp_length_error)
);
`default_nettype wire
